// ===== rtl/core/pfde_pkg.sv =====
package pfde_pkg;

  localparam int unsigned PAGES_DEF   = 8;
  localparam int unsigned COLUMNS_DEF = 128;

  typedef enum logic [2:0] {
    FN_CLEAR_ALL = 3'd0,
    FN_SET_PIXEL = 3'd1,
    FN_GET_PIXEL = 3'd2,
    FN_CLEAR_RECT = 3'd3,
    FN_OR_BYTE   = 3'd4,
    FN_READ_BYTE = 3'd5,
    FN_LINE      = 3'd6,
    FN_NOP       = 3'd7
  } func_e;

  // one store access handed from the sequencer to the store
  typedef struct packed {
    logic       valid;  // access in flight
    logic       rmw;    // read, then write back (a | set) & ~clr
    logic       last;   // final access of the command
    logic       resp;   // result taken from this read
    logic       bitsel; // result is one pixel bit
    logic [2:0] bitpos;
    logic [7:0] set;
    logic [7:0] clr;
  } acc_t;

endpackage

// ===== rtl/core/page_framebuffer_draw_engine.sv =====
// result word: the sequencer issues the accepted command's store access, the store read stage
//   registers it and the output word register takes the result (or byte across two pages: two accesses)
// clear rect/all: one store access per covered pixel, clearing its bit (clear all: whole store)
// line: per drawn point a serial divide for rounding, then one store access
// one command at a time; the next is accepted the cycle after its word is taken
// reset: async active low; then the whole store is cleared with the input stalled
module page_framebuffer_draw_engine #(
  parameter int unsigned PAGES   = pfde_pkg::PAGES_DEF,
  parameter int unsigned COLUMNS = pfde_pkg::COLUMNS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [6:0] x_i,
  input  logic [5:0] y_i,
  input  logic [6:0] x_end_i,
  input  logic [5:0] y_end_i,
  input  logic [7:0] width_i,
  input  logic [6:0] height_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);
  localparam int unsigned AW = ((PAGES > 1) ? $clog2(PAGES) : 0) + $clog2(COLUMNS);

  logic           busy, done, resp, start, pend_q;
  logic [7:0]     rdata;
  pfde_pkg::acc_t acc;
  logic [AW-1:0]  addr;

  // one command in flight until its word is taken
  assign in_stall_o = busy || pend_q || out_valid_o;
  assign start      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (start) begin
      pend_q <= 1'b1;
    end else if (done) begin
      pend_q <= 1'b0;
    end
  end

  // output word register, the clearing pass after reset gives no word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      read_data_o <= '0;
    end else if (done && pend_q) begin
      out_valid_o <= 1'b1;
      read_data_o <= resp ? rdata : 8'd0;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  pfde_seq #(.PAGES(PAGES), .COLUMNS(COLUMNS), .AW(AW)) u_seq (
    .clk_i, .rst_ni, .start_i(start), .func_i, .x_i, .y_i, .x_end_i, .y_end_i,
    .width_i, .height_i, .data_i, .busy_o(busy), .acc_o(acc), .addr_o(addr)
  );

  pfde_store #(.AW(AW)) u_store (
    .clk_i, .rst_ni, .acc_i(acc), .addr_i(addr), .done_o(done), .resp_o(resp),
    .rdata_o(rdata)
  );
endmodule

// ===== rtl/core/pfde_store.sv =====
module pfde_store #(
  parameter int unsigned AW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfde_pkg::acc_t     acc_i,
  input  logic [AW-1:0]      addr_i,
  output logic               done_o,
  output logic               resp_o,
  output logic [7:0]         rdata_o
);
  logic [7:0]    mem [2**AW];
  logic [7:0]    rd_q;
  pfde_pkg::acc_t acc_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    wr;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;
  logic [7:0]    rd;

  // read stage
  always_ff @(posedge clk_i) begin
    rd_q       <= mem[addr_i];
    addr_q     <= addr_i;
    fwd_data_q <= wr;
  end

  // back to back access of the same byte takes the byte being written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      acc_q <= acc_i;
      fwd_q <= acc_q.valid && acc_q.rmw && (addr_q == addr_i);
    end
  end

  assign rd = fwd_q ? fwd_data_q : rd_q;

  // modify and write back
  assign wr = (rd | acc_q.set) & ~acc_q.clr;
  always_ff @(posedge clk_i) begin
    if (acc_q.valid && acc_q.rmw) begin
      mem[addr_q] <= wr;
    end
  end

  assign done_o  = acc_q.valid && acc_q.last;
  assign resp_o  = acc_q.resp;
  assign rdata_o = acc_q.bitsel ? {7'd0, rd[acc_q.bitpos]} : rd;
endmodule

// ===== rtl/core/pfde_seq.sv =====
module pfde_seq #(
  parameter int unsigned PAGES   = pfde_pkg::PAGES_DEF,
  parameter int unsigned COLUMNS = pfde_pkg::COLUMNS_DEF,
  parameter int unsigned AW      = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2:0]     func_i,
  input  logic [6:0]     x_i,
  input  logic [5:0]     y_i,
  input  logic [6:0]     x_end_i,
  input  logic [5:0]     y_end_i,
  input  logic [7:0]     width_i,
  input  logic [6:0]     height_i,
  input  logic [7:0]     data_i,
  output logic           busy_o,
  output pfde_pkg::acc_t acc_o,
  output logic [AW-1:0]  addr_o
);
  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [11:0] ROWS = 12'(PAGES * 8);
  localparam logic [11:0] COLS = 12'(COLUMNS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ONE   = 6'b000010,
    S_OR2   = 6'b000100,
    S_WALK  = 6'b001000,
    S_LDIV  = 6'b010000,
    S_DRAIN = 6'b100000
  } state_e;

  state_e      st_q, st_d;
  logic [2:0]  fn_q;
  logic [11:0] x_q, y_q, xe_q, ye_q;      // walk cursor and limits
  logic [11:0] x0_q, y0_q;                // rect origin
  logic [7:0]  data_q;
  // line
  logic        lx_q;                      // step along x
  logic [11:0] s0_q, m0_q, dmaj_q, t_q;
  logic signed [12:0] dmin_q;
  logic [23:0] num_q, den2_q;
  logic [11:0] quo_q;
  logic [4:0]  dcnt_q;
  logic [24:0] rem_q;

  logic        ok;
  logic [11:0] col, row;
  pfde_pkg::acc_t a;

  assign busy_o = (st_q != S_IDLE);

  // address of the current pixel or byte
  always_comb begin
    col = x_q;
    row = y_q;
    if (st_q == S_OR2) begin
      row = y_q + 12'd8;
    end
    if (st_q == S_LDIV) begin
      col = lx_q ? (s0_q + t_q) : quo_q;
      row = lx_q ? quo_q : (s0_q + t_q);
    end
    ok = (col < COLS) && (row[11:3] < 9'(PAGES));
    addr_o = AW'({row[3 +: PW], col[CW-1:0]});
    if (PAGES == 1) addr_o = AW'(col[CW-1:0]);
  end

  // after reset the whole store is walked and cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_WALK;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    logic [2:0]  sh;
    logic [15:0] wide;
    sh   = y_q[2:0];
    wide = {8'd0, data_q} << sh;
    a    = '0;
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          st_d = S_ONE;
        end
      end
      S_ONE: begin
        a.valid = 1'b1;
        a.last  = 1'b1;
        case (pfde_pkg::func_e'(fn_q))
          pfde_pkg::FN_SET_PIXEL: begin
            a.rmw = ok;
            a.set = 8'd1 << sh;
          end
          pfde_pkg::FN_GET_PIXEL: begin
            a.resp = ok; a.bitsel = 1'b1; a.bitpos = sh;
          end
          pfde_pkg::FN_READ_BYTE: a.resp = ok;
          pfde_pkg::FN_OR_BYTE: begin
            a.rmw = ok;
            a.set = wide[7:0];
            a.last = (sh == 3'd0);
          end
          default: ;
        endcase
        st_d = S_DRAIN;
        if (pfde_pkg::func_e'(fn_q) == pfde_pkg::FN_OR_BYTE && sh != 3'd0) st_d = S_OR2;
        if (pfde_pkg::func_e'(fn_q) == pfde_pkg::FN_CLEAR_ALL ||
            pfde_pkg::func_e'(fn_q) == pfde_pkg::FN_CLEAR_RECT) begin
          a = '0; st_d = S_WALK;
        end
        if (pfde_pkg::func_e'(fn_q) == pfde_pkg::FN_LINE) begin
          a = '0; st_d = S_LDIV;
        end
      end
      S_OR2: begin
        a.valid = 1'b1; a.last = 1'b1;
        a.rmw = ok; a.set = wide[15:8];
        st_d = S_DRAIN;
      end
      S_WALK: begin
        // walks the rectangle pixel by pixel, a byte per cycle, the pixel row picked by mask
        a.valid = 1'b1;
        a.rmw   = ok && (x_q < xe_q) && (y_q < ye_q);
        a.clr   = 8'd1 << y_q[2:0];
        if (x_q + 12'd1 >= xe_q || x_q + 12'd1 >= COLS) begin
          if (y_q + 12'd1 >= ye_q || y_q + 12'd1 >= ROWS) begin
            a.last = 1'b1; st_d = S_DRAIN;
          end
        end
        if (x_q >= xe_q || x_q >= COLS || y_q >= ye_q) begin
          a.last = 1'b1; st_d = S_DRAIN; a.rmw = 1'b0;
        end
      end
      S_LDIV: begin
        if (dcnt_q == 5'd25) begin
          a.valid = 1'b1; a.rmw = ok; a.set = 8'd1 << row[2:0];
          if (t_q == dmaj_q) begin
            a.last = 1'b1; st_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    acc_o = a;
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [12:0] adx, ady;
    logic        swp;
    logic [24:0] r;
    if (!rst_ni) begin
      fn_q   <= pfde_pkg::FN_CLEAR_ALL;
      data_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      x0_q   <= '0;
      xe_q   <= COLS;
      ye_q   <= ROWS;
      lx_q   <= 1'b0;
      s0_q   <= '0;
      m0_q   <= '0;
      dmaj_q <= '0;
      dmin_q <= '0;
      t_q    <= '0;
      num_q  <= '0;
      den2_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dcnt_q <= 5'd31;
    end else if (start_i && st_q == S_IDLE) begin
      fn_q   <= func_i;
      data_q <= data_i;
      x_q    <= {5'd0, x_i};
      y_q    <= {6'd0, y_i};
      x0_q   <= {5'd0, x_i};
      xe_q   <= {5'd0, x_i} + {4'd0, width_i};
      ye_q   <= {6'd0, y_i} + {5'd0, height_i};
      if (pfde_pkg::func_e'(func_i) == pfde_pkg::FN_CLEAR_ALL) begin
        x_q <= '0; y_q <= '0; x0_q <= '0; xe_q <= COLS; ye_q <= ROWS;
      end
      // line setup
      adx = (x_end_i > x_i) ? 13'(x_end_i - x_i) : 13'(x_i - x_end_i);
      ady = (y_end_i > y_i) ? 13'(y_end_i - y_i) : 13'(y_i - y_end_i);
      lx_q <= (ady < adx);
      swp  = (ady < adx) ? (x_i > x_end_i) : (y_i > y_end_i);
      if (ady < adx) begin
        s0_q   <= swp ? 12'(x_end_i) : 12'(x_i);
        m0_q   <= swp ? 12'(y_end_i) : 12'(y_i);
        dmaj_q <= adx[11:0];
        dmin_q <= swp ? 13'(y_i) - 13'(y_end_i) : 13'(y_end_i) - 13'(y_i);
      end else begin
        s0_q   <= swp ? 12'(y_end_i) : 12'(y_i);
        m0_q   <= swp ? 12'(x_end_i) : 12'(x_i);
        dmaj_q <= ady[11:0];
        dmin_q <= swp ? 13'(x_i) - 13'(x_end_i) : 13'(x_end_i) - 13'(x_i);
      end
      t_q    <= '0;
      dcnt_q <= 5'd31;
    end else if (st_q == S_WALK) begin
      if (x_q + 12'd1 >= xe_q || x_q + 12'd1 >= COLS) begin
        x_q <= x0_q;
        y_q <= y_q + 12'd1;
      end else begin
        x_q <= x_q + 12'd1;
      end
    end else if (st_q == S_LDIV) begin
      // restoring divide: (2n + den) / (2den), one quotient bit a cycle
      if (dcnt_q == 5'd31) begin
        logic signed [24:0] n;
        n = $signed({1'b0, 12'd0, m0_q}) * $signed({12'd0, dmaj_q})
          + $signed({12'd0, t_q}) * dmin_q;
        if (dmaj_q == 12'd0) n = $signed({13'd0, m0_q});
        if (n < 0) n = '0;
        num_q  <= 24'(2 * n + ((dmaj_q == 0) ? 25'd1 : 25'(dmaj_q)));
        den2_q <= (dmaj_q == 0) ? 24'd2 : {11'd0, dmaj_q, 1'b0};
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= 5'd0;
      end else if (dcnt_q < 5'd24) begin
        r = {rem_q[23:0], num_q[23]};
        num_q <= {num_q[22:0], 1'b0};
        if (r >= {1'b0, den2_q}) begin
          rem_q <= r - {1'b0, den2_q};
          quo_q <= {quo_q[10:0], 1'b1};
        end else begin
          rem_q <= r;
          quo_q <= {quo_q[10:0], 1'b0};
        end
        dcnt_q <= (dcnt_q == 5'd23) ? 5'd25 : dcnt_q + 5'd1;
      end else begin
        t_q    <= t_q + 12'd1;
        dcnt_q <= 5'd31;
      end
    end
  end
endmodule
